@@ design/tlam_pkg.sv @@
// Shared types, constants and sine table for the tremolo modulator.
package tlam_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 8;

  localparam int STEP_BITS  = 32;
  localparam int DEPTH_BITS = 16;
  localparam int LFO_BITS   = 16;
  localparam int TRI_BITS   = 16;
  localparam int SINE_BITS  = 15;
  localparam int GAIN_FRAC  = 30;
  localparam int GAIN_BITS  = GAIN_FRAC + 1;
  localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;

  localparam int SINE_N     = 1 << SINE_TABLE_BITS;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int REG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [REG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_DEPTH      = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_WAVEFORM   = 2'd2;

  localparam logic [STEP_BITS-1:0]  RESET_PHASE_STEP = 32'd178957;
  localparam logic [DEPTH_BITS-1:0] ONE_Q15          = 16'd32768;
  localparam logic [LFO_BITS-1:0]   HALF_Q15         = 16'd16384;
  localparam logic [TRI_BITS-1:0]   TRI_RISE_END     = 16'd16384;
  localparam logic [TRI_BITS-1:0]   TRI_FALL_END     = 16'd49152;
  localparam logic [SINE_BITS-1:0]  SINE_PEAK        = 15'd16384;
  localparam logic [GAIN_BITS-1:0]  ONE_Q30          = GAIN_BITS'(1) << GAIN_FRAC;

  localparam logic WAVE_SINE     = 1'b0;
  localparam logic WAVE_TRIANGLE = 1'b1;

  localparam real SINE_STEP = 3.14159265358979323846 / (2.0 * SINE_N);

  typedef struct packed {
    logic [STEP_BITS-1:0]  phase_step;
    logic [DEPTH_BITS-1:0] depth;
    logic                  waveform;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [LFO_BITS-1:0]           lfo;
  } item_t;

  typedef logic [SINE_N-1:0][SINE_BITS-1:0] sine_rom_t;

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    real       x;
    real       s;
    for (int i = 0; i < SINE_N; i++) begin
      x = SINE_STEP * i;
      s = 16384.0 * $sin(x) + 0.5;
      rom[i] = SINE_BITS'($rtoi(s));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

@@ design/tlam_front.sv @@
// Front end: phase accumulator, LFO lookup and queue push.
module tlam_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tlam_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tlam_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                 q_full,
  output logic                                 q_push,
  output tlam_pkg::item_t                      q_item
);
  import tlam_pkg::*;

  logic [PHASE_BITS-1:0]      phase;
  logic [TRI_BITS-1:0]        tri_t;
  logic [SINE_TABLE_BITS+1:0] top;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS-1:0] ridx;
  logic [SINE_BITS-1:0]       sv;
  logic [LFO_BITS-1:0]        lfo;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  assign tri_t = phase[PHASE_BITS-1 -: TRI_BITS];
  assign top   = phase[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
  assign quad  = top[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
  assign idx   = top[SINE_TABLE_BITS-1:0];
  assign ridx  = ~idx + 1'b1;

  always_comb begin
    if (quad[0]) begin
      sv = (idx == '0) ? SINE_PEAK : SINE_ROM[ridx];
    end else begin
      sv = SINE_ROM[idx];
    end
    if (cfg.waveform == WAVE_TRIANGLE) begin
      if (tri_t < TRI_RISE_END) begin
        lfo = HALF_Q15 + tri_t;
      end else if (tri_t < TRI_FALL_END) begin
        lfo = TRI_FALL_END - tri_t;
      end else begin
        lfo = tri_t - TRI_FALL_END;
      end
    end else if (quad[1]) begin
      lfo = HALF_Q15 - LFO_BITS'(sv);
    end else begin
      lfo = HALF_Q15 + LFO_BITS'(sv);
    end
  end

  assign q_item.sample = in_sample;
  assign q_item.lfo    = lfo;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (q_push) begin
      phase <= phase + PHASE_BITS'(cfg.phase_step);
    end
  end

endmodule

@@ design/tlam_fifo.sv @@
// Two-entry queue between front and back ends.
module tlam_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlam_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output tlam_pkg::item_t pop_item
);
  import tlam_pkg::*;

  item_t                entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/tlam_back.sv @@
// Back end: gain multiply, sample multiply and output register.
module tlam_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tlam_pkg::cfg_t                        cfg,
  input  logic                                  q_not_empty,
  input  tlam_pkg::item_t                       q_item,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tlam_pkg::SAMPLE_BITS-1:0] out_sample
);
  import tlam_pkg::*;

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [GAIN_BITS-1:0]          s1_prod;
  logic [DEPTH_BITS-1:0]         depth_sat;
  logic [GAIN_BITS-1:0]          gain;
  logic signed [PROD_BITS-1:0]   scaled;
  logic                          s1_take;
  logic                          s2_load;

  assign depth_sat = (cfg.depth > ONE_Q15) ? ONE_Q15 : cfg.depth;
  assign s2_load   = s1_valid && (!out_valid || out_ready);
  assign s1_take   = !s1_valid || s2_load;
  assign q_pop     = q_not_empty && s1_take;

  assign gain   = ONE_Q30 - s1_prod;
  assign scaled = PROD_BITS'(s1_sample) * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_sample <= q_item.sample;
      s1_prod   <= GAIN_BITS'(depth_sat) * GAIN_BITS'(q_item.lfo);
    end
    if (s2_load) begin
      out_sample <= scaled[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= q_not_empty;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/tremolo_lfo_amplitude_modulator.sv @@
// Top level of the tremolo modulator: registers, front end, queue, back end.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   in       | in_valid / in_ready     | in_sample (16 bit signed)
//   out      | out_valid / out_ready   | out_sample (16 bit signed)
//   config   | wr_en                   | wr_index (2 bit), wr_data (32 bit)
//
// One sample per cycle sustained while out_ready is held high. A transfer in
// is written to the queue, then registered by the queue read into the gain
// multiply stage and by the sample multiply into the out register.
// The phase accumulator advances once per input transfer.
// Synchronous reset clears phase, queue and pipeline valids and loads the
// register defaults.
// Output stalls back up through the pipeline into the two-entry queue;
// in_ready drops only when the queue is full.
module tremolo_lfo_amplitude_modulator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    wr_en,
  input  logic [tlam_pkg::REG_INDEX_BITS-1:0]     wr_index,
  input  logic [tlam_pkg::CFG_DATA_BITS-1:0]      wr_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [tlam_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [tlam_pkg::SAMPLE_BITS-1:0] out_sample
);
  import tlam_pkg::*;

  cfg_t  cfg;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_in;
  item_t q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= RESET_PHASE_STEP;
      cfg.depth      <= ONE_Q15;
      cfg.waveform   <= WAVE_SINE;
    end else if (wr_en) begin
      case (wr_index)
        REG_PHASE_STEP: cfg.phase_step <= wr_data[STEP_BITS-1:0];
        REG_DEPTH:      cfg.depth      <= wr_data[DEPTH_BITS-1:0];
        REG_WAVEFORM:   cfg.waveform   <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  tlam_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  tlam_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out)
  );

  tlam_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample)
  );

endmodule
